// File: sv/imufoc_pkg.sv
// ----------------------------------------------------------------------------
// imufoc_pkg
// Shared widths, request codes and the result record of the motion-sensor
// burst unpacker with offset calibration.
// ----------------------------------------------------------------------------
package imufoc_pkg;

    localparam int REQ_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int GRAV_W      = 15;
    localparam int POS_W       = 4;
    localparam int N_CHAN      = 6;
    localparam int FRAME_BYTES = 14;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 15'd16384;
    localparam logic [POS_W-1:0]  POS_LAST      = POS_W'(FRAME_BYTES - 1);

    // Request codes carried in req_type; code 3 is unused and ignored.
    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE  = 2'd0,
        REQ_START = 2'd1,
        REQ_FAIL  = 2'd2
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] accel_x;
        logic signed [WORD_W-1:0] accel_y;
        logic signed [WORD_W-1:0] accel_z;
        logic signed [WORD_W-1:0] temperature;
        logic signed [WORD_W-1:0] gyro_x;
        logic signed [WORD_W-1:0] gyro_y;
        logic signed [WORD_W-1:0] gyro_z;
        logic                     calib_done;
        logic                     read_error;
    } t_imu_res;

endpackage

// File: sv/imufoc_in_if.sv
// ----------------------------------------------------------------------------
// imufoc_in_if
// Input channel: one request item (burst byte, start, or failed read).
// ----------------------------------------------------------------------------
interface imufoc_in_if import imufoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// File: sv/imufoc_out_if.sv
// ----------------------------------------------------------------------------
// imufoc_out_if
// Result channel: corrected frame, new offsets, or a read error item.
// ----------------------------------------------------------------------------
interface imufoc_out_if import imufoc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic signed [WORD_W-1:0] temperature;
    logic signed [WORD_W-1:0] gyro_x;
    logic signed [WORD_W-1:0] gyro_y;
    logic signed [WORD_W-1:0] gyro_z;
    logic                     calib_done;
    logic                     read_error;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output temperature, output gyro_x, output gyro_y, output gyro_z,
                    output calib_done, output read_error, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input temperature, input gyro_x, input gyro_y, input gyro_z,
                    input calib_done, input read_error, output ready);
endinterface

// File: sv/imufoc_cfg_if.sv
// ----------------------------------------------------------------------------
// imufoc_cfg_if
// Configuration write channel for the gravity count register.
// ----------------------------------------------------------------------------
interface imufoc_cfg_if import imufoc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GRAV_W-1:0] gravity_counts;

    modport source (output valid, output gravity_counts, input ready);
    modport sink   (input valid, input gravity_counts, output ready);
endinterface

// File: sv/imu_frame_unpack_offset_calibrate.sv
// ----------------------------------------------------------------------------
// imu_frame_unpack_offset_calibrate
// Unpacks the 14-byte big-endian motion-sensor burst into seven words,
// removes stored offsets, and runs the averaging offset calibration.
// ----------------------------------------------------------------------------
// A result is registered in the cycle after the item that causes it, except
// the calibration result, which passes through r_fin and the finishing step.
// One item per cycle while the result register is free; no item is taken
// while r_fin turns the sums into offsets at the end of each calibration run.
// Reset clears framing, offsets, sums, the attempt count and the calibration
// flag, and loads gravity_counts with 16384. No clearing pass is needed.
module imu_frame_unpack_offset_calibrate
    import imufoc_pkg::*;
#(
    parameter int CAL_SAMPLES_LOG2 = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    imufoc_in_if.sink    i_in,
    imufoc_cfg_if.sink   i_cfg,
    imufoc_out_if.source o_out
);

    // The run length is a power of two, so the average is a biased shift.
    localparam int N_SMP = 1 << CAL_SAMPLES_LOG2;
    localparam int CNT_W = CAL_SAMPLES_LOG2 + 1;
    // A sum of N_SMP signed 16-bit words always fits in this many bits.
    localparam int SUM_W = WORD_W + CAL_SAMPLES_LOG2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_SMP - 1);
    localparam logic [SUM_W-1:0] DIV_BIAS = SUM_W'(N_SMP - 1);

    // Control state.
    logic [POS_W-1:0]         r_pos,    n_pos;
    logic [CNT_W-1:0]         r_count,  n_count;
    logic                     r_calib,  n_calib;
    logic                     r_fin,    n_fin;
    logic                     r_ov,     n_ov;
    logic [GRAV_W-1:0]        r_grav;
    logic signed [SUM_W-1:0]  r_sum [N_CHAN];
    logic signed [SUM_W-1:0]  n_sum [N_CHAN];
    logic [WORD_W-1:0]        r_ofs [N_CHAN];
    logic [WORD_W-1:0]        n_ofs [N_CHAN];

    // Payload state: the held high byte, the first six frame words and the
    // result register. These are always written before they are used.
    logic [BYTE_W-1:0]        r_hold;
    logic [WORD_W-1:0]        r_words [N_CHAN];
    t_imu_res                 r_res,    n_res;

    logic                     in_acc;
    logic                     slot_free;
    logic                     fin_go;
    logic                     wr_word;
    logic [WORD_W-1:0]        cur_word;
    logic [WORD_W-1:0]        chan [N_CHAN];
    logic [WORD_W-1:0]        q_ofs [N_CHAN];

    // The result register is free when empty or being drained this cycle.
    assign slot_free   = !r_ov || o_out.ready;
    // While the offsets are being finished, no new item is taken.
    assign i_in.ready  = !r_fin && slot_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign fin_go      = r_fin && slot_free;
    assign i_cfg.ready = 1'b1;

    // The low byte completes a word together with the held high byte.
    assign cur_word = {r_hold, i_in.data_byte};
    assign wr_word  = in_acc && (t_req'(i_in.req_type) == REQ_BYTE) && r_pos[0]
                      && (r_pos[POS_W-1:1] < 3'(N_CHAN));

    // Channel order: accel X, Y, Z, gyro X, Y, Z. Gyro Z is the last word of
    // the burst, so it is taken straight from the incoming byte pair.
    assign chan[0] = r_words[0];
    assign chan[1] = r_words[1];
    assign chan[2] = r_words[2];
    assign chan[3] = r_words[4];
    assign chan[4] = r_words[5];
    assign chan[5] = cur_word;

    // Offsets from the sums: divide toward zero by adding N_SMP-1 to a
    // negative sum before the arithmetic shift. Gravity comes off Z accel.
    always_comb begin
        logic [SUM_W-1:0] biased;
        logic [WORD_W-1:0] q;
        for (int k = 0; k < N_CHAN; k++) begin
            biased = r_sum[k] + (r_sum[k][SUM_W-1] ? DIV_BIAS : '0);
            q      = biased[CAL_SAMPLES_LOG2 +: WORD_W];
            if (k == 2) begin
                q_ofs[k] = q - {1'b0, r_grav};
            end else begin
                q_ofs[k] = q;
            end
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_count = r_count;
        n_calib = r_calib;
        n_fin   = r_fin;
        n_sum   = r_sum;
        n_ofs   = r_ofs;
        n_res   = r_res;
        n_ov    = r_ov && !o_out.ready;

        if (fin_go) begin
            // Second half of a run's last attempt: publish the new offsets.
            n_fin            = 1'b0;
            n_ofs            = q_ofs;
            n_res            = '0;
            n_res.accel_x    = q_ofs[0];
            n_res.accel_y    = q_ofs[1];
            n_res.accel_z    = q_ofs[2];
            n_res.gyro_x     = q_ofs[3];
            n_res.gyro_y     = q_ofs[4];
            n_res.gyro_z     = q_ofs[5];
            n_res.calib_done = 1'b1;
            n_ov             = 1'b1;
        end else if (in_acc) begin
            case (t_req'(i_in.req_type))
                REQ_START: begin
                    // A start during a run simply restarts it.
                    for (int k = 0; k < N_CHAN; k++) begin
                        n_sum[k] = '0;
                    end
                    n_count = '0;
                    n_calib = 1'b1;
                    n_pos   = '0;
                end
                REQ_FAIL: begin
                    n_pos = '0;
                    if (r_calib) begin
                        // A failed read still counts as an attempt.
                        n_count = r_count + 1'b1;
                        if (r_count == CNT_LAST) begin
                            n_fin   = 1'b1;
                            n_calib = 1'b0;
                        end
                    end else begin
                        n_res            = '0;
                        n_res.read_error = 1'b1;
                        n_ov             = 1'b1;
                    end
                end
                REQ_BYTE: begin
                    if (!r_pos[0]) begin
                        n_pos = r_pos + 1'b1;
                    end else if (r_pos != POS_LAST) begin
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_pos = '0;
                        if (r_calib) begin
                            for (int k = 0; k < N_CHAN; k++) begin
                                n_sum[k] = r_sum[k] + SUM_W'(signed'(chan[k]));
                            end
                            n_count = r_count + 1'b1;
                            if (r_count == CNT_LAST) begin
                                n_fin   = 1'b1;
                                n_calib = 1'b0;
                            end
                        end else begin
                            n_res             = '0;
                            n_res.accel_x     = chan[0] - r_ofs[0];
                            n_res.accel_y     = chan[1] - r_ofs[1];
                            n_res.accel_z     = chan[2] - r_ofs[2];
                            n_res.temperature = r_words[3];
                            n_res.gyro_x      = chan[3] - r_ofs[3];
                            n_res.gyro_y      = chan[4] - r_ofs[4];
                            n_res.gyro_z      = chan[5] - r_ofs[5];
                            n_ov              = 1'b1;
                        end
                    end
                end
                default: begin
                    // Unused request code: no state change, no result.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_calib <= 1'b0;
            r_fin   <= 1'b0;
            r_ov    <= 1'b0;
            r_grav  <= GRAVITY_RESET;
            for (int k = 0; k < N_CHAN; k++) begin
                r_sum[k] <= '0;
                r_ofs[k] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_calib <= n_calib;
            r_fin   <= n_fin;
            r_ov    <= n_ov;
            r_sum   <= n_sum;
            r_ofs   <= n_ofs;
            if (i_cfg.valid) begin
                r_grav <= i_cfg.gravity_counts;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_acc && (t_req'(i_in.req_type) == REQ_BYTE) && !r_pos[0]) begin
            r_hold <= i_in.data_byte;
        end
        if (wr_word) begin
            r_words[r_pos[POS_W-1:1]] <= cur_word;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.accel_x     = r_res.accel_x;
    assign o_out.accel_y     = r_res.accel_y;
    assign o_out.accel_z     = r_res.accel_z;
    assign o_out.temperature = r_res.temperature;
    assign o_out.gyro_x      = r_res.gyro_x;
    assign o_out.gyro_y      = r_res.gyro_y;
    assign o_out.gyro_z      = r_res.gyro_z;
    assign o_out.calib_done  = r_res.calib_done;
    assign o_out.read_error  = r_res.read_error;

    // Framing never runs past the last byte of a burst.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position out of range");

    // Finishing a run only happens once the full attempt count is reached.
    a_fin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_count == CNT_W'(N_SMP)) && !r_calib)
        else $error("offset finish without a full run");

    // A start request leaves an empty, active run behind.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_req'(i_in.req_type) == REQ_START)
        |=> r_calib && (r_count == '0) && (r_pos == '0))
        else $error("start request did not reset the run");

    // A calibration result carries no temperature and no error flag.
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_res.calib_done |-> (r_res.temperature == '0) && !r_res.read_error)
        else $error("calibration result has stray fields");

    // A finishing cycle always loads the result register.
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> r_ov && r_res.calib_done && !r_fin)
        else $error("calibration result not issued");

endmodule

// File: sim/tb_imu_frame_unpack_offset_calibrate.sv
// ----------------------------------------------------------------------------
// tb_imu_frame_unpack_offset_calibrate
// Self-checking bench for the motion-sensor burst unpacker with offset
// calibration. It starts with a short table of directed items, then moves
// through four phases. The first and the third phase set the gravity count
// and run one full calibration; every phase then streams mostly well-formed
// bursts mixed with aborted ones, failed reads and ignored codes. Every
// result is compared field by field against a cycle-free prediction of the
// unpacker.
// ----------------------------------------------------------------------------
module tb_imu_frame_unpack_offset_calibrate;
    import imufoc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CAL_LOG2     = 8;
    localparam longint CAL_N        = longint'(1) << CAL_LOG2;
    localparam int     PHASE_ITEMS  = 150;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     CYCLE_LIMIT  = 200000;

    // Code 3 is not part of the request enum; the block must ignore it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam t_imu_res ERR_RES = '{read_error: 1'b1, default: '0};

    // One burst with the word extremes; offsets are zero after reset, so the
    // result is just the raw words.
    localparam t_imu_res EXTREME_FRAME = '{
        accel_x: 16'sh7FFF, accel_y: 16'sh8000, accel_z: 16'shFFFF,
        temperature: 16'sh0000, gyro_x: 16'sh0001, gyro_y: 16'sh8000,
        gyro_z: 16'sh7FFF, default: '0
    };

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] data;
        bit                typed;
        t_imu_res          res;
    } t_dir_row;

    // Directed items. A typed result is checked as written; every other row
    // is checked against the predictor.
    t_dir_row directed_rows [24] = '{
        '{REQ_FAIL,   8'h00, 1'b1, ERR_RES},        // failed read right after reset
        '{REQ_UNUSED, 8'hA5, 1'b0, '0},             // ignored code
        '{REQ_BYTE,   8'h7F, 1'b0, '0},
        '{REQ_BYTE,   8'hFF, 1'b0, '0},
        '{REQ_BYTE,   8'h80, 1'b0, '0},
        '{REQ_BYTE,   8'h00, 1'b0, '0},
        '{REQ_BYTE,   8'hFF, 1'b0, '0},
        '{REQ_BYTE,   8'hFF, 1'b0, '0},
        '{REQ_BYTE,   8'h00, 1'b0, '0},
        '{REQ_BYTE,   8'h00, 1'b0, '0},
        '{REQ_BYTE,   8'h00, 1'b0, '0},
        '{REQ_BYTE,   8'h01, 1'b0, '0},
        '{REQ_BYTE,   8'h80, 1'b0, '0},
        '{REQ_BYTE,   8'h00, 1'b0, '0},
        '{REQ_BYTE,   8'h7F, 1'b0, '0},
        '{REQ_BYTE,   8'hFF, 1'b1, EXTREME_FRAME},
        '{REQ_BYTE,   8'h12, 1'b0, '0},             // partial burst ...
        '{REQ_BYTE,   8'h34, 1'b0, '0},
        '{REQ_BYTE,   8'h56, 1'b0, '0},
        '{REQ_FAIL,   8'h00, 1'b1, ERR_RES},        // ... aborted by a failed read
        '{REQ_UNUSED, 8'h3C, 1'b0, '0},
        '{REQ_FAIL,   8'hFF, 1'b1, ERR_RES},        // data is don't-care here
        '{REQ_START,  8'h00, 1'b0, '0},             // enters calibration
        '{REQ_BYTE,   8'h55, 1'b0, '0}              // half word inside the run
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    imufoc_in_if  in_ch ();
    imufoc_cfg_if cfg_ch ();
    imufoc_out_if res_ch ();

    imu_frame_unpack_offset_calibrate #(
        .CAL_SAMPLES_LOG2(CAL_LOG2)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predicted state of the unpacker. It is advanced once per accepted item,
    // in acceptance order, so the queue of pending readings lines up with the
    // order in which the block delivers its results.
    // ------------------------------------------------------------------------
    logic [POS_W-1:0]  burst_pos;
    logic [WORD_W-1:0] word_buf [7];
    logic [BYTE_W-1:0] high_hold;
    logic [WORD_W-1:0] offset_reg [N_CHAN];
    longint            offset_sum [N_CHAN];
    int unsigned       attempt_cnt;
    bit                cal_running;
    logic [GRAV_W-1:0] gravity_reg;

    t_imu_res pending_readings [$];

    // Stimulus and checker control.
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_token     = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          items_sent     = 0;
    int          error_cnt      = 0;
    int unsigned cycle_cnt      = 0;
    t_imu_res    head_reading;
    logic [WORD_W-1:0] cal_base [N_CHAN];

    // Counts one calibration attempt. When the run is complete the offsets
    // are the sums divided toward zero, with gravity taken off the vertical
    // accel channel, and a calibration-done reading is produced.
    function automatic bit count_attempt(output t_imu_res res);
        longint q;
        res = '0;
        attempt_cnt++;
        if (longint'(attempt_cnt) < CAL_N) begin
            return 1'b0;
        end
        for (int k = 0; k < N_CHAN; k++) begin
            q = offset_sum[k] / CAL_N;
            if (k == 2) begin
                q = q - longint'(gravity_reg);
            end
            offset_reg[k] = q[WORD_W-1:0];
        end
        cal_running    = 1'b0;
        res.accel_x    = offset_reg[0];
        res.accel_y    = offset_reg[1];
        res.accel_z    = offset_reg[2];
        res.gyro_x     = offset_reg[3];
        res.gyro_y     = offset_reg[4];
        res.gyro_z     = offset_reg[5];
        res.calib_done = 1'b1;
        return 1'b1;
    endfunction

    // Advances the predicted state by one item; returns 1 with the reading
    // that the item should cause, or 0 when it causes none.
    function automatic bit unpack_and_correct(input logic [REQ_W-1:0] req,
                                              input logic [BYTE_W-1:0] data,
                                              output t_imu_res res);
        int w;
        res = '0;
        case (req)
            REQ_START: begin
                // A start always clears the sums, even in the middle of a run.
                for (int k = 0; k < N_CHAN; k++) begin
                    offset_sum[k] = 0;
                end
                attempt_cnt = 0;
                cal_running = 1'b1;
                burst_pos   = '0;
                return 1'b0;
            end
            REQ_FAIL: begin
                burst_pos = '0;
                if (cal_running) begin
                    return count_attempt(res);
                end
                res.read_error = 1'b1;
                return 1'b1;
            end
            REQ_BYTE: begin
                if (!burst_pos[0]) begin
                    high_hold = data;
                    burst_pos = burst_pos + 1'b1;
                    return 1'b0;
                end
                word_buf[burst_pos >> 1] = {high_hold, data};
                if (burst_pos != POS_LAST) begin
                    burst_pos = burst_pos + 1'b1;
                    return 1'b0;
                end
                burst_pos = '0;
                if (cal_running) begin
                    // Temperature (word 3) does not take part in calibration.
                    for (int k = 0; k < N_CHAN; k++) begin
                        w = (k < 3) ? k : k + 1;
                        offset_sum[k] += longint'($signed(word_buf[w]));
                    end
                    return count_attempt(res);
                end
                res.accel_x     = word_buf[0] - offset_reg[0];
                res.accel_y     = word_buf[1] - offset_reg[1];
                res.accel_z     = word_buf[2] - offset_reg[2];
                res.temperature = word_buf[3];
                res.gyro_x      = word_buf[4] - offset_reg[3];
                res.gyro_y      = word_buf[5] - offset_reg[4];
                res.gyro_z      = word_buf[6] - offset_reg[5];
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom);
    endfunction

    // Sensor words lean toward the corners of the signed range, where a
    // subtract or a sign extension is most likely to go wrong.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Offers one item and waits for it to be taken. The valid line stays
    // high between back-to-back items; it only drops during a random gap.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data,
                         input bit typed, input t_imu_res typed_res);
        t_imu_res res;
        bit       has_res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.data_byte <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        has_res = unpack_and_correct(req, data, res);
        if (typed) begin
            pending_readings.push_back(typed_res);
        end else if (has_res) begin
            pending_readings.push_back(res);
        end
        // Ignored codes do not count toward the stimulus budget.
        if (req != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data);
        offer(req, data, 1'b0, '0);
    endtask

    task automatic send_partial(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            send_item(REQ_BYTE, rand_byte());
        end
    endtask

    // Sends one complete 14-byte burst. Inside a calibration run each channel
    // word has an even chance to repeat a per-run base value so the sums grow large.
    // With noise on, ignored codes are slipped in between bytes.
    task automatic send_frame(input bit in_cal, input bit noisy);
        logic [WORD_W-1:0] words [7];
        for (int i = 0; i < 7; i++) begin
            if (in_cal && i != 3 && $urandom_range(1) == 0) begin
                words[i] = cal_base[(i < 3) ? i : i - 1];
            end else begin
                words[i] = pick_word();
            end
        end
        for (int i = 0; i < 14; i++) begin
            if (noisy && $urandom_range(5) == 0) begin
                send_item(REQ_UNUSED, rand_byte());
            end
            send_item(REQ_BYTE, i[0] ? words[i >> 1][7:0] : words[i >> 1][15:8]);
        end
    endtask

    // One calibration run driven to completion. Most attempts are failed
    // reads to keep the run short; a start part way in restarts the run.
    task automatic calibration_run(input int frame_one_in);
        int restart_at;
        int step;
        for (int k = 0; k < N_CHAN; k++) begin
            cal_base[k] = pick_word();
        end
        send_item(REQ_START, rand_byte());
        restart_at = $urandom_range(2, 40);
        step = 0;
        while (cal_running) begin
            step++;
            if (step == restart_at) begin
                send_partial($urandom_range(0, 13));
                send_item(REQ_START, rand_byte());
            end else if ($urandom_range(frame_one_in - 1) == 0) begin
                send_frame(1'b1, $urandom_range(7) == 0);
            end else begin
                if ($urandom_range(15) == 0) begin
                    send_partial($urandom_range(1, 13));
                end
                send_item(REQ_FAIL, rand_byte());
            end
        end
    endtask

    // Traffic outside calibration: mostly clean bursts with random content,
    // the rest aborted bursts, lone failed reads and ignored codes.
    task automatic normal_episode();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            send_frame(1'b0, 1'b0);
        end else if (pick < 78) begin
            send_frame(1'b0, 1'b1);
        end else if (pick < 88) begin
            send_partial($urandom_range(1, 13));
            send_item(REQ_FAIL, rand_byte());
        end else if (pick < 96) begin
            send_item(REQ_FAIL, rand_byte());
        end else begin
            send_item(REQ_UNUSED, rand_byte());
        end
    endtask

    // The register is only written while the block is idle. A start item
    // causes no result, so the task waits on past an empty queue to let such an
    // item settle before the write goes in.
    task automatic write_gravity(input logic [GRAV_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.gravity_counts <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        gravity_reg = value;
    endtask

    function automatic void check_field(input string name,
                                        input logic signed [WORD_W-1:0] want_v,
                                        input logic signed [WORD_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side. A result is taken at an edge where valid and ready were
    // both high and is compared with the oldest pending reading. The ready
    // line stalls at random, and on request it is held low for a long
    // stretch so that the block backs up into its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_readings.size() == 0) begin
                    $error("result with nothing pending: calib_done %0b, read_error %0b",
                           res_ch.calib_done, res_ch.read_error);
                    error_cnt++;
                end else begin
                    head_reading = pending_readings.pop_front();
                    check_field("accel_x", head_reading.accel_x, res_ch.accel_x);
                    check_field("accel_y", head_reading.accel_y, res_ch.accel_y);
                    check_field("accel_z", head_reading.accel_z, res_ch.accel_z);
                    check_field("temperature", head_reading.temperature,
                                res_ch.temperature);
                    check_field("gyro_x", head_reading.gyro_x, res_ch.gyro_x);
                    check_field("gyro_y", head_reading.gyro_y, res_ch.gyro_y);
                    check_field("gyro_z", head_reading.gyro_z, res_ch.gyro_z);
                    check_field("calib_done", WORD_W'(head_reading.calib_done),
                                WORD_W'(res_ch.calib_done));
                    check_field("read_error", WORD_W'(head_reading.read_error),
                                WORD_W'(res_ch.read_error));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then four phases that each
    // stream ordinary traffic under a different idling pattern. The first
    // and the third phase set the gravity count and calibrate beforehand.
    // ------------------------------------------------------------------------
    initial begin
        int                phase_start;
        logic [GRAV_W-1:0] grav;
        bit                do_cal;

        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.req_type        = REQ_BYTE;
        in_ch.data_byte       = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.gravity_counts = '0;

        burst_pos   = '0;
        high_hold   = '0;
        attempt_cnt = 0;
        cal_running = 1'b0;
        gravity_reg = GRAVITY_RESET;
        grav        = '0;
        for (int k = 0; k < 7; k++) begin
            word_buf[k] = '0;
        end
        for (int k = 0; k < N_CHAN; k++) begin
            offset_reg[k] = '0;
            offset_sum[k] = 0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].req, directed_rows[i].data,
                  directed_rows[i].typed, directed_rows[i].res);
        end

        // The directed table leaves a run open; the first phase restarts it.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    do_cal         = 1'b1;
                    grav           = 15'h7FFF;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                    do_cal         = 1'b0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                    do_cal         = 1'b1;
                    grav           = 15'h0000;
                end
                default: begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                    do_cal         = 1'b0;
                end
            endcase
            if (do_cal) begin
                write_gravity(grav);
                calibration_run((ph == 0) ? 10 : 24);
            end
            // With no idling on either side, a long receiver hold-off while
            // the sender keeps offering fills the block and stalls its input.
            if (ph == 0) begin
                hold_token++;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                normal_episode();
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
